FILE: rtl/core/tme_pkg.sv
`default_nettype none

package tme_pkg;

    // Default sizes of the weight matrix
    localparam int MAX_THRUSTERS_DEF = 8;
    localparam int MAX_AXES_DEF      = 6;

    // Axis command fields carried by one drive transaction
    localparam int AXIS_FIELDS = 6;

    // Field widths
    localparam int ACTION_W = 1;
    localparam int SEL_W    = 3;
    localparam int VALUE_W  = 16;
    localparam int INDEX_W  = 3;
    localparam int CODE_W   = 8;

    // Q9.27 sum scaled to a code
    localparam int FRAC_BITS = 27;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int THR_CFG_W  = 4;
    localparam int AXES_CFG_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_THRUSTERS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_AXES      = 2'd1;

    localparam logic [THR_CFG_W-1:0]  THR_CFG_RESET  = 4'd8;
    localparam logic [AXES_CFG_W-1:0] AXES_CFG_RESET = 3'd6;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_LOAD  = 1'b0;
    localparam logic [ACTION_W-1:0] ACT_DRIVE = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_EMIT
    } t_ctrl_state;

    typedef struct packed {
        logic wr_en;       // write one weight
        logic latch_axes;  // capture the drive vector
        logic issue;       // read one weight and start one product
        logic first;       // product opens a new row sum
        logic emit;        // load the output register with the row code
        logic emit_last;   // row is the final one of the drive
    } t_dp_cmd;

    typedef struct packed {
        logic pipe_empty;  // no product in flight, row sum is final
        logic out_free;    // output register can take a code this cycle
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: rtl/core/tme_in_if.sv
`default_nettype none

interface tme_in_if import tme_pkg::*; ();

    logic                      valid;
    logic                      ready;
    logic [ACTION_W-1:0]       action;
    logic [SEL_W-1:0]          row_sel;
    logic [SEL_W-1:0]          col_sel;
    logic signed [VALUE_W-1:0] weight_value;
    logic signed [VALUE_W-1:0] axis0;
    logic signed [VALUE_W-1:0] axis1;
    logic signed [VALUE_W-1:0] axis2;
    logic signed [VALUE_W-1:0] axis3;
    logic signed [VALUE_W-1:0] axis4;
    logic signed [VALUE_W-1:0] axis5;

    modport source (
        output valid, action, row_sel, col_sel, weight_value,
        output axis0, axis1, axis2, axis3, axis4, axis5,
        input  ready
    );

    modport sink (
        input  valid, action, row_sel, col_sel, weight_value,
        input  axis0, axis1, axis2, axis3, axis4, axis5,
        output ready
    );

endinterface

`default_nettype wire

FILE: rtl/core/tme_out_if.sv
`default_nettype none

interface tme_out_if import tme_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] thruster_index;
    logic [CODE_W-1:0]  throttle_code;
    logic               last;

    modport source (
        output valid, thruster_index, throttle_code, last,
        input  ready
    );

    modport sink (
        input  valid, thruster_index, throttle_code, last,
        output ready
    );

endinterface

`default_nettype wire

FILE: rtl/core/tme_ctrl.sv
`default_nettype none

module tme_ctrl import tme_pkg::*; #(
    parameter int MAX_THRUSTERS = MAX_THRUSTERS_DEF,
    parameter int MAX_AXES      = MAX_AXES_DEF,
    localparam int RW  = (MAX_THRUSTERS > 1) ? $clog2(MAX_THRUSTERS) : 1,
    localparam int JW  = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1,
    localparam int TCW = $clog2(MAX_THRUSTERS + 1),
    localparam int ACW = $clog2(MAX_AXES + 1)
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire                   i_in_valid,
    input  wire [ACTION_W-1:0]    i_action,
    input  wire [SEL_W-1:0]       i_row_sel,
    input  wire [SEL_W-1:0]       i_col_sel,
    input  t_dp_sts               i_sts,
    output logic                  o_in_ready,
    output t_dp_cmd               o_cmd,
    output logic [RW-1:0]         o_row,
    output logic [JW-1:0]         o_col
);

    t_ctrl_state r_state, n_state;
    logic [RW-1:0] r_row, n_row;
    logic [JW-1:0] r_col, n_col;
    logic [THR_CFG_W-1:0]  r_active_thr;
    logic [AXES_CFG_W-1:0] r_active_axes;

    logic [TCW-1:0] rows_use;
    logic [ACW-1:0] cols_use;
    logic accept, last_row, last_col, load_ok;

    // Saturate the register values to the matrix size; a zero value counts as one
    always_comb begin
        if (r_active_thr == '0) begin
            rows_use = TCW'(1);
        end else if (int'(r_active_thr) > MAX_THRUSTERS) begin
            rows_use = TCW'(MAX_THRUSTERS);
        end else begin
            rows_use = TCW'(r_active_thr);
        end
        if (r_active_axes == '0) begin
            cols_use = ACW'(1);
        end else if (int'(r_active_axes) > MAX_AXES) begin
            cols_use = ACW'(MAX_AXES);
        end else begin
            cols_use = ACW'(r_active_axes);
        end
    end

    assign accept   = i_in_valid && o_in_ready;
    assign last_row = (int'(r_row) + 1 == int'(rows_use));
    assign last_col = (int'(r_col) + 1 == int'(cols_use));
    assign load_ok  = (int'(i_row_sel) < MAX_THRUSTERS) && (int'(i_col_sel) < MAX_AXES);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_action == ACT_DRIVE) begin
                    n_state = S_MAC;
                end
            end
            S_MAC: begin
                if (last_col) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_sts.pipe_empty) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = last_row ? S_IDLE : S_MAC;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        o_cmd.first      = (r_col == '0);
        o_cmd.emit_last  = last_row;
        case (r_state)
            S_IDLE: begin
                o_in_ready       = 1'b1;
                o_cmd.wr_en      = accept && (i_action == ACT_LOAD) && load_ok;
                o_cmd.latch_axes = accept && (i_action == ACT_DRIVE);
            end
            S_MAC: begin
                o_cmd.issue = 1'b1;
            end
            S_EMIT: begin
                o_cmd.emit = i_sts.out_free;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        case (r_state)
            S_IDLE: begin
                n_row = '0;
                n_col = '0;
            end
            S_MAC: begin
                n_col = last_col ? '0 : r_col + JW'(1);
            end
            S_EMIT: begin
                if (i_sts.out_free && !last_row) begin
                    n_row = r_row + RW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_row = r_row;
    assign o_col = r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_row         <= '0;
            r_col         <= '0;
            r_active_thr  <= THR_CFG_RESET;
            r_active_axes <= AXES_CFG_RESET;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            if (i_cfg_we && i_cfg_idx == CFG_ACTIVE_THRUSTERS) begin
                r_active_thr <= i_cfg_data[THR_CFG_W-1:0];
            end
            if (i_cfg_we && i_cfg_idx == CFG_ACTIVE_AXES) begin
                r_active_axes <= i_cfg_data[AXES_CFG_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/tme_dp.sv
`default_nettype none

module tme_dp import tme_pkg::*; #(
    parameter int MAX_THRUSTERS = MAX_THRUSTERS_DEF,
    parameter int MAX_AXES      = MAX_AXES_DEF,
    localparam int RW    = (MAX_THRUSTERS > 1) ? $clog2(MAX_THRUSTERS) : 1,
    localparam int JW    = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1,
    localparam int DEPTH = MAX_THRUSTERS * MAX_AXES,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  t_dp_cmd                                i_cmd,
    input  wire [RW-1:0]                           i_row,
    input  wire [JW-1:0]                           i_col,
    input  wire [SEL_W-1:0]                        i_ld_row,
    input  wire [SEL_W-1:0]                        i_ld_col,
    input  wire [VALUE_W-1:0]                      i_ld_weight,
    input  wire [AXIS_FIELDS-1:0][VALUE_W-1:0]     i_axis,
    input  wire                                    i_out_ready,
    output t_dp_sts                                o_sts,
    output logic                                   o_out_valid,
    output logic [INDEX_W-1:0]                     o_out_index,
    output logic [CODE_W-1:0]                      o_out_code,
    output logic                                   o_out_last
);

    localparam int PROD_W = 2 * VALUE_W;
    localparam int SUM_W  = PROD_W + $clog2(MAX_AXES) + 1;
    localparam int VW     = SUM_W + 8;
    localparam logic signed [VW-1:0] CODE_HI = VW'(128) <<< FRAC_BITS;
    localparam logic signed [VW-1:0] CODE_LO = -(VW'(127) <<< FRAC_BITS);

    logic [VALUE_W-1:0] r_mem [DEPTH];

    logic [AW-1:0] wr_addr, rd_addr;
    logic signed [VALUE_W-1:0] r_axis [AXIS_FIELDS];
    logic signed [VALUE_W-1:0] axis_sel;
    logic signed [VALUE_W-1:0] r_rd_data, r_axis_q;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [SUM_W-1:0]   r_acc;
    logic signed [VW-1:0]      scaled;
    logic [CODE_W-1:0]         code;
    logic r_v1, r_v2, r_first1, r_first2;

    assign wr_addr = AW'(int'(i_ld_row) * MAX_AXES + int'(i_ld_col));
    assign rd_addr = AW'(int'(i_row) * MAX_AXES + int'(i_col));

    // Columns past the carried axis fields read as zero
    always_comb begin
        axis_sel = '0;
        for (int k = 0; k < AXIS_FIELDS; k++) begin
            if (int'(i_col) == k) begin
                axis_sel = r_axis[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= i_ld_weight;
        end
        if (i_cmd.issue) begin
            r_rd_data <= signed'(r_mem[rd_addr]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_axes) begin
            for (int k = 0; k < AXIS_FIELDS; k++) begin
                r_axis[k] <= signed'(i_axis[k]);
            end
        end
        if (i_cmd.issue) begin
            r_axis_q <= axis_sel;
            r_first1 <= i_cmd.first;
        end
        if (r_v1) begin
            r_prod   <= r_rd_data * r_axis_q;
            r_first2 <= r_first1;
        end
        if (r_v2) begin
            r_acc <= r_first2 ? SUM_W'(r_prod) : r_acc + SUM_W'(r_prod);
        end
    end

    // code = floor(127 * sum / 2^27) + 128, saturated to 1..255
    assign scaled = (VW'(r_acc) <<< 7) - VW'(r_acc);

    always_comb begin
        if (scaled >= CODE_HI) begin
            code = 8'd255;
        end else if (scaled < CODE_LO) begin
            code = 8'd1;
        end else begin
            code = CODE_W'((scaled + CODE_HI) >>> FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            if (i_cmd.emit) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_out_index <= INDEX_W'(i_row);
            o_out_code  <= code;
            o_out_last  <= i_cmd.emit_last;
        end
    end

    assign o_sts.pipe_empty = !r_v1 && !r_v2;
    assign o_sts.out_free   = !o_out_valid || i_out_ready;

endmodule

`default_nettype wire

FILE: rtl/core/thruster_mix_and_encode_core.sv
`default_nettype none

// Channel   Dir  Role     Payload
// i_in      in   sink     action, row_sel, col_sel, weight_value, axis0..axis5
// o_out     out  source   thruster_index, throttle_code, last
// i_cfg_*   in   write    register index, data (active_thrusters, active_axes)
//
// A load transaction writes its weight at its accept edge. During a drive,
// each row streams its columns through the single multiply-accumulate path
// (one weight read per cycle from the matrix memory), drains that path and
// then waits for the output register to be free. Reset idles the controller
// and sets the configuration registers to their defaults; matrix weights are
// undefined until loaded. A stalled output holds the row code and holds the
// next row in the encoder; the input is taken again once the last code is stored.

module thruster_mix_and_encode_core import tme_pkg::*; #(
    parameter int MAX_THRUSTERS = MAX_THRUSTERS_DEF,
    parameter int MAX_AXES      = MAX_AXES_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [CFG_DATA_W-1:0] i_cfg_data,
    tme_in_if.sink               i_in,
    tme_out_if.source            o_out
);

    localparam int RW = (MAX_THRUSTERS > 1) ? $clog2(MAX_THRUSTERS) : 1;
    localparam int JW = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic [RW-1:0] row;
    logic [JW-1:0] col;
    logic [AXIS_FIELDS-1:0][VALUE_W-1:0] axis_vec;

    // Gather the drive vector in field order
    assign axis_vec = {i_in.axis5, i_in.axis4, i_in.axis3,
                       i_in.axis2, i_in.axis1, i_in.axis0};

    // Sequence rows and columns, hold configuration
    tme_ctrl #(
        .MAX_THRUSTERS (MAX_THRUSTERS),
        .MAX_AXES      (MAX_AXES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in.valid),
        .i_action   (i_in.action),
        .i_row_sel  (i_in.row_sel),
        .i_col_sel  (i_in.col_sel),
        .i_sts      (sts),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd),
        .o_row      (row),
        .o_col      (col)
    );

    // Weight memory, multiply-accumulate, encoder and output register
    tme_dp #(
        .MAX_THRUSTERS (MAX_THRUSTERS),
        .MAX_AXES      (MAX_AXES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_row       (row),
        .i_col       (col),
        .i_ld_row    (i_in.row_sel),
        .i_ld_col    (i_in.col_sel),
        .i_ld_weight (i_in.weight_value),
        .i_axis      (axis_vec),
        .i_out_ready (o_out.ready),
        .o_sts       (sts),
        .o_out_valid (o_out.valid),
        .o_out_index (o_out.thruster_index),
        .o_out_code  (o_out.throttle_code),
        .o_out_last  (o_out.last)
    );

endmodule

`default_nettype wire
